### hw/rtl/ncu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncu_pkg
// Shared types, constants and UTF-8 helpers for the numeric reference decoder.
// ----------------------------------------------------------------------------
package ncu_pkg;

  localparam int NCU_MAX_DIGITS = 7;
  localparam int MAX_RESULTS    = 10;
  localparam int RES_W          = 4;    // holds 0..MAX_RESULTS

  localparam logic [20:0] CODE_MAX     = 21'h1FFFFF;
  localparam logic [20:0] CODE_REPLACE = 21'h00FFFD;
  localparam logic [7:0]  LIMIT_RESET  = 8'd64;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_AMP,
    MODE_HASH
  } ncu_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAKE,
    ST_MUL,
    ST_ADD,
    ST_PLAIN,
    ST_FL_AMP,
    ST_FL_HASH,
    ST_FL_DIG,
    ST_ENC,
    ST_ENC_BYTE,
    ST_END,
    ST_DONE,
    ST_OUT
  } ncu_state_t;

  // where the sequencer goes once a literal flush is finished
  typedef enum logic {
    FN_PLAIN,
    FN_DONE
  } ncu_flush_next_t;

  typedef struct packed {
    logic       push;
    logic [7:0] data;
  } ncu_wr_t;

  typedef struct packed {
    logic start;
    logic last;
    logic trunc;
  } ncu_drain_t;

  typedef struct packed {
    logic [RES_W-1:0] count;
    logic             done;
  } ncu_qstat_t;

  function automatic logic [2:0] utf8_len(logic [20:0] c);
    logic [2:0] n;
    if (c < 21'h80) n = 3'd1;
    else if (c < 21'h800) n = 3'd2;
    else if (c < 21'h10000) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

  // byte idx (0 = lead) of the len-byte UTF-8 form of c
  function automatic logic [7:0] utf8_byte(logic [20:0] c, logic [2:0] len,
                                           logic [1:0] idx);
    logic [1:0] rem;
    logic [5:0] chunk;
    logic [7:0] r;
    rem = 2'(len - 3'd1 - {1'b0, idx});
    case (rem)
      2'd0:    chunk = c[5:0];
      2'd1:    chunk = c[11:6];
      2'd2:    chunk = c[17:12];
      default: chunk = {3'b000, c[20:18]};
    endcase
    if (idx == 2'd0) begin
      case (len)
        3'd1:    r = {1'b0, c[6:0]};
        3'd2:    r = {3'b110, c[10:6]};
        3'd3:    r = {4'b1110, c[15:12]};
        default: r = {5'b11110, c[20:18]};
      endcase
    end else begin
      r = {2'b10, chunk};
    end
    return r;
  endfunction

endpackage

### hw/rtl/ncu_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncu_outq
// Collects the bytes of one request, then drains them with the status flags.
// ----------------------------------------------------------------------------
module ncu_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  ncu_pkg::ncu_wr_t    wr,
  input  ncu_pkg::ncu_drain_t drain,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_run_last,
  output logic                out_string_end,
  output logic                out_truncated,
  output logic                out_byte_valid,
  output ncu_pkg::ncu_qstat_t qstat
);

  logic [7:0]                qbuf_r [ncu_pkg::MAX_RESULTS];
  logic [ncu_pkg::RES_W-1:0] cnt_r, cnt_nxt;
  logic [ncu_pkg::RES_W-1:0] rd_r, rd_nxt;
  logic                      busy_r, busy_nxt;
  logic                      status_r, status_nxt;
  logic                      last_r, last_nxt;
  logic                      trunc_r, trunc_nxt;
  logic                      fin;

  always_comb begin
    // drain ends on the last byte, or on the status-only result when a string ends with nothing to show
    fin = busy_r && !out_stall &&
          (status_r || rd_r == ncu_pkg::RES_W'(cnt_r - 1'b1));
    cnt_nxt    = cnt_r;
    rd_nxt     = rd_r;
    busy_nxt   = busy_r;
    status_nxt = status_r;
    last_nxt   = last_r;
    trunc_nxt  = trunc_r;
    if (wr.push && !busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (drain.start) begin
      busy_nxt   = 1'b1;
      rd_nxt     = '0;
      status_nxt = (cnt_r == '0);
      last_nxt   = drain.last;
      trunc_nxt  = drain.trunc;
    end else if (fin) begin
      busy_nxt   = 1'b0;
      cnt_nxt    = '0;
      status_nxt = 1'b0;
    end else if (busy_r && !out_stall) begin
      rd_nxt = rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_r     <= '0;
      busy_r   <= 1'b0;
      status_r <= 1'b0;
      last_r   <= 1'b0;
      trunc_r  <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_r     <= rd_nxt;
      busy_r   <= busy_nxt;
      status_r <= status_nxt;
      last_r   <= last_nxt;
      trunc_r  <= trunc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push && !busy_r) begin
      qbuf_r[cnt_r] <= wr.data;
    end
  end

  assign out_valid      = busy_r;
  assign out_byte       = status_r ? 8'h00 : qbuf_r[rd_r];
  assign out_run_last   = status_r || (rd_r == ncu_pkg::RES_W'(cnt_r - 1'b1));
  assign out_string_end = out_run_last && last_r;
  assign out_truncated  = trunc_r;
  assign out_byte_valid = !status_r;
  assign qstat.count    = cnt_r;
  assign qstat.done     = fin;

endmodule

### hw/rtl/numeric_entity_to_utf8_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_entity_to_utf8_decoder
// Replaces "&#NNN;" references in a byte stream by UTF-8, passes other bytes.
// ----------------------------------------------------------------------------
// Steps: accept, take, end and done, plus a plain-byte or '&' step, a multiply and
//   an add for a digit, the encode step and its UTF-8 bytes closing a reference, or a
//   literal flush; then one result per cycle unless stalled.
// Throughput: one request at a time, set by the sequencer and the shared adder.
// Reset: synchronous active-low rst_n clears parse state and counts; limit 64.
module numeric_entity_to_utf8_decoder #(
  parameter int MAX_DIGITS = ncu_pkg::NCU_MAX_DIGITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end,
  output logic       out_truncated,
  output logic       out_byte_valid,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int DIG_IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int DC_W   = $clog2(MAX_DIGITS + 1);

  ncu_pkg::ncu_state_t      state_r, state_nxt;
  ncu_pkg::ncu_mode_t       mode_r, mode_nxt;
  ncu_pkg::ncu_flush_next_t cont_r, cont_nxt;
  logic [20:0]              acc_r, acc_nxt;
  logic [24:0]              tmp_r, tmp_nxt;
  logic [DC_W-1:0]          dc_r, dc_nxt;
  logic [DC_W-1:0]          k_r, k_nxt;
  logic [7:0]               emit_r, emit_nxt;
  logic                     drop_r, drop_nxt;
  logic [7:0]               b_r, b_nxt;
  logic                     last_r, last_nxt;
  logic [7:0]               limit_r;
  logic [1:0]               j_r, j_nxt;
  logic [2:0]               elen_r, elen_nxt;
  logic [3:0]               dig_r [MAX_DIGITS];

  ncu_pkg::ncu_wr_t    wr;
  ncu_pkg::ncu_drain_t drain;
  ncu_pkg::ncu_qstat_t qstat;

  logic        dig_we;
  logic [3:0]  dig_val;
  logic        is_digit;
  logic [20:0] c_eff;
  logic [2:0]  enc_len;
  logic [2:0]  len_sel;
  logic [7:0]  cap;
  logic        ok;
  logic [24:0] add_a, add_b, sum;
  logic        emit1;
  logic [7:0]  emit_data;
  logic        fl_fin;
  logic        ref_clr;

  assign dig_val  = 4'(b_r - ncu_pkg::CH_0);
  assign is_digit = (b_r >= ncu_pkg::CH_0) && (b_r <= ncu_pkg::CH_9);
  assign c_eff    = (acc_r == '0) ? ncu_pkg::CODE_REPLACE : acc_r;
  assign enc_len  = ncu_pkg::utf8_len(c_eff);

  // shared room check: whole group fits the limit and the result queue
  assign len_sel = (state_r == ncu_pkg::ST_ENC) ? enc_len : 3'd1;
  assign cap     = (limit_r == 8'd0) ? 8'd0 : 8'(limit_r - 8'd1);
  assign ok      = !drop_r &&
                   (({1'b0, emit_r} + 9'(len_sel)) <= {1'b0, cap}) &&
                   (({1'b0, qstat.count} + 5'(len_sel)) <=
                    5'(ncu_pkg::MAX_RESULTS));

  // shared adder: acc*10 in one pass, + digit in the next
  always_comb begin
    if (state_r == ncu_pkg::ST_MUL) begin
      add_a = {1'b0, acc_r, 3'b000};
      add_b = {3'b000, acc_r, 1'b0};
    end else begin
      add_a = tmp_r;
      add_b = 25'(dig_val);
    end
  end
  assign sum = add_a + add_b;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cont_nxt  = cont_r;
    acc_nxt   = acc_r;
    tmp_nxt   = tmp_r;
    dc_nxt    = dc_r;
    k_nxt     = k_r;
    emit_nxt  = emit_r;
    drop_nxt  = drop_r;
    b_nxt     = b_r;
    last_nxt  = last_r;
    j_nxt     = j_r;
    elen_nxt  = elen_r;
    in_stall  = 1'b1;
    dig_we    = 1'b0;
    emit1     = 1'b0;
    emit_data = b_r;
    fl_fin    = 1'b0;
    ref_clr   = 1'b0;
    wr.push   = 1'b0;
    wr.data   = b_r;
    drain.start = 1'b0;
    drain.last  = last_r;
    drain.trunc = drop_r;

    case (state_r)
      ncu_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          b_nxt     = in_byte;
          last_nxt  = in_last;
          state_nxt = ncu_pkg::ST_TAKE;
        end
      end
      ncu_pkg::ST_TAKE: begin
        case (mode_r)
          ncu_pkg::MODE_AMP: begin
            if (b_r == ncu_pkg::CH_HASH) begin
              mode_nxt  = ncu_pkg::MODE_HASH;
              ref_clr   = 1'b1;
              state_nxt = ncu_pkg::ST_END;
            end else begin
              cont_nxt  = ncu_pkg::FN_PLAIN;
              state_nxt = ncu_pkg::ST_FL_AMP;
            end
          end
          ncu_pkg::MODE_HASH: begin
            if (is_digit && dc_r < DC_W'(MAX_DIGITS)) begin
              dig_we    = 1'b1;
              dc_nxt    = dc_r + 1'b1;
              state_nxt = ncu_pkg::ST_MUL;
            end else if (b_r == ncu_pkg::CH_SEMI && dc_r != '0) begin
              state_nxt = ncu_pkg::ST_ENC;
            end else begin
              cont_nxt  = ncu_pkg::FN_PLAIN;
              state_nxt = ncu_pkg::ST_FL_AMP;
            end
          end
          default: begin
            state_nxt = ncu_pkg::ST_PLAIN;
          end
        endcase
      end
      ncu_pkg::ST_MUL: begin
        tmp_nxt   = sum;
        state_nxt = ncu_pkg::ST_ADD;
      end
      ncu_pkg::ST_ADD: begin
        acc_nxt   = (sum > 25'(ncu_pkg::CODE_MAX)) ? ncu_pkg::CODE_MAX : sum[20:0];
        state_nxt = ncu_pkg::ST_END;
      end
      ncu_pkg::ST_PLAIN: begin
        if (b_r == ncu_pkg::CH_AMP) begin
          mode_nxt = ncu_pkg::MODE_AMP;
        end else begin
          emit1 = 1'b1;
        end
        state_nxt = ncu_pkg::ST_END;
      end
      ncu_pkg::ST_FL_AMP: begin
        emit1     = 1'b1;
        emit_data = ncu_pkg::CH_AMP;
        if (mode_r == ncu_pkg::MODE_HASH) begin
          state_nxt = ncu_pkg::ST_FL_HASH;
        end else begin
          fl_fin = 1'b1;
        end
      end
      ncu_pkg::ST_FL_HASH: begin
        emit1     = 1'b1;
        emit_data = ncu_pkg::CH_HASH;
        k_nxt     = '0;
        state_nxt = ncu_pkg::ST_FL_DIG;
      end
      ncu_pkg::ST_FL_DIG: begin
        if (k_r < dc_r) begin
          emit1     = 1'b1;
          emit_data = ncu_pkg::CH_0 + {4'b0000, dig_r[k_r[DIG_IW-1:0]]};
          k_nxt     = k_r + 1'b1;
        end else begin
          fl_fin = 1'b1;
        end
      end
      ncu_pkg::ST_ENC: begin
        if (ok) begin
          emit_nxt  = emit_r + 8'(enc_len);
          j_nxt     = '0;
          elen_nxt  = enc_len;
          state_nxt = ncu_pkg::ST_ENC_BYTE;
        end else begin
          drop_nxt  = 1'b1;
          mode_nxt  = ncu_pkg::MODE_PLAIN;
          ref_clr   = 1'b1;
          state_nxt = ncu_pkg::ST_END;
        end
      end
      ncu_pkg::ST_ENC_BYTE: begin
        wr.push = 1'b1;
        wr.data = ncu_pkg::utf8_byte(c_eff, elen_r, j_r);
        j_nxt   = j_r + 1'b1;
        if (j_r == 2'(elen_r - 3'd1)) begin
          mode_nxt  = ncu_pkg::MODE_PLAIN;
          ref_clr   = 1'b1;
          state_nxt = ncu_pkg::ST_END;
        end
      end
      ncu_pkg::ST_END: begin
        if (last_r && mode_r != ncu_pkg::MODE_PLAIN) begin
          cont_nxt  = ncu_pkg::FN_DONE;
          state_nxt = ncu_pkg::ST_FL_AMP;
        end else begin
          state_nxt = ncu_pkg::ST_DONE;
        end
      end
      ncu_pkg::ST_DONE: begin
        if (qstat.count != '0 || last_r) begin
          drain.start = 1'b1;
          state_nxt   = ncu_pkg::ST_OUT;
        end else begin
          state_nxt = ncu_pkg::ST_IDLE;
        end
      end
      ncu_pkg::ST_OUT: begin
        if (qstat.done) begin
          if (last_r) begin
            mode_nxt = ncu_pkg::MODE_PLAIN;
            ref_clr  = 1'b1;
            emit_nxt = '0;
            drop_nxt = 1'b0;
          end
          state_nxt = ncu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ncu_pkg::ST_IDLE;
      end
    endcase

    // single-byte emit through the shared room check
    if (emit1) begin
      if (ok) begin
        wr.push  = 1'b1;
        wr.data  = emit_data;
        emit_nxt = emit_r + 8'd1;
      end else begin
        drop_nxt = 1'b1;
      end
    end

    if (fl_fin) begin
      mode_nxt  = ncu_pkg::MODE_PLAIN;
      ref_clr   = 1'b1;
      state_nxt = (cont_r == ncu_pkg::FN_PLAIN) ? ncu_pkg::ST_PLAIN : ncu_pkg::ST_DONE;
    end

    if (ref_clr) begin
      dc_nxt  = '0;
      acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ncu_pkg::ST_IDLE;
      mode_r  <= ncu_pkg::MODE_PLAIN;
      cont_r  <= ncu_pkg::FN_PLAIN;
      acc_r   <= '0;
      dc_r    <= '0;
      k_r     <= '0;
      emit_r  <= '0;
      drop_r  <= 1'b0;
      last_r  <= 1'b0;
      j_r     <= '0;
      elen_r  <= 3'd1;
      limit_r <= ncu_pkg::LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      cont_r  <= cont_nxt;
      acc_r   <= acc_nxt;
      dc_r    <= dc_nxt;
      k_r     <= k_nxt;
      emit_r  <= emit_nxt;
      drop_r  <= drop_nxt;
      last_r  <= last_nxt;
      j_r     <= j_nxt;
      elen_r  <= elen_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_r   <= b_nxt;
    tmp_r <= tmp_nxt;
    if (dig_we) begin
      dig_r[dc_r[DIG_IW-1:0]] <= dig_val;
    end
  end

  assign cfg_ready = 1'b1;

  ncu_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr             (wr),
    .drain          (drain),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end),
    .out_truncated  (out_truncated),
    .out_byte_valid (out_byte_valid),
    .qstat          (qstat)
  );

`ifndef SYNTHESIS
  a_out_only_draining: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ncu_pkg::ST_OUT)
    else $error("result shown outside drain phase");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    wr.push |-> qstat.count < ncu_pkg::RES_W'(ncu_pkg::MAX_RESULTS))
    else $error("result queue overflow");

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input taken while results pending");

  a_drain_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ncu_pkg::ST_OUT && qstat.done) |=> state_r == ncu_pkg::ST_IDLE)
    else $error("sequencer did not return to idle after drain");

  a_string_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_string_end) |=>
      (mode_r == ncu_pkg::MODE_PLAIN && emit_r == '0 && !drop_r))
    else $error("string state not cleared at end of string");
`endif

endmodule
